FILE: design/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths, codes and types of the bilinear pixel sampler.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int FRAC_BITS_DEF  = 10;

   localparam int COORD_W    = 26;
   localparam int INDEX_W    = 12;
   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int CHAN_N     = 4;
   localparam int CORNER_N   = 4;
   localparam int DIM_W      = 7;
   localparam int REQ_DATA_W = INDEX_W + PIXEL_W + 2 * COORD_W;
   localparam int RSP_DATA_W = PIXEL_W;

   localparam int WEIGHT_SHIFT = 10;
   localparam int WEIGHT_W     = WEIGHT_SHIFT + 1;
   localparam int PROD_W       = CHAN_W + WEIGHT_W;
   localparam int ACC_W        = PROD_W + 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_SHIFT;
   localparam logic [CHAN_W-1:0]   CHAN_MAX   = 8'hFF;
   localparam logic [DIM_W-1:0]    DIM_RESET  = 7'd64;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic [WEIGHT_W-1:0] tl;
      logic [WEIGHT_W-1:0] tr;
      logic [WEIGHT_W-1:0] bl;
      logic [WEIGHT_W-1:0] br;
      logic                oor;
   } bps_weights_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] tl;
      logic [PIXEL_W-1:0] tr;
      logic [PIXEL_W-1:0] bl;
      logic [PIXEL_W-1:0] br;
   } bps_corners_type;

endpackage

FILE: design/bps_bank.sv
// ----------------------------------------------------------------------------
// bps_bank
// Frame store bank: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bps_bank #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [bps_pkg::PIXEL_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr_a,
   input  logic [ADDR_W-1:0]           rd_addr_b,
   output logic [bps_pkg::PIXEL_W-1:0] rd_data_a,
   output logic [bps_pkg::PIXEL_W-1:0] rd_data_b
);
   import bps_pkg::*;

   logic [PIXEL_W-1:0] store_ff [DEPTH];
   logic [PIXEL_W-1:0] rd_a_ff;
   logic [PIXEL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: design/bps_front.sv
// ----------------------------------------------------------------------------
// bps_front
// Input stage: frame store writes, neighbour addresses, corner weights.
// ----------------------------------------------------------------------------
module bps_front #(
   parameter int MAX_WIDTH  = bps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bps_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = bps_pkg::FRAC_BITS_DEF,
   parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic [bps_pkg::DIM_W-1:0]      width_eff,
   input  logic [bps_pkg::DIM_W-1:0]      height_eff,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [bps_pkg::PIXEL_W-1:0]    wr_data,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr_tl,
   output logic [ADDR_W-1:0]              rd_addr_tr,
   output logic [ADDR_W-1:0]              rd_addr_bl,
   output logic [ADDR_W-1:0]              rd_addr_br,
   output logic                           s2_valid,
   input  logic                           s2_ready,
   output bps_pkg::bps_weights_type       s2_weights
);
   import bps_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int SUM_W = XW + YW + DIM_W;
   localparam int PW    = 2 * FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic                 v1_ff, v1_in;
   logic                 kind1_ff;
   logic [INDEX_W-1:0]   idx1_ff;
   logic [PIXEL_W-1:0]   pix1_ff;
   logic [COORD_W-1:0]   xc1_ff;
   logic [COORD_W-1:0]   yc1_ff;
   logic                 v2_ff, v2_in;
   bps_weights_type      wt2_ff;

   logic                 accept;
   logic                 leave;
   logic                 adv1;
   logic                 is_sample;
   logic [31:0]          idx_ext;
   logic [COORD_W-1:0]   lim_x, lim_y;
   logic                 oor;
   logic [XW-1:0]        col1, col2;
   logic [YW-1:0]        row1, row2;
   logic [XW:0]          col2_pre;
   logic [YW:0]          row2_pre;
   logic [DIM_W-1:0]     last_col, last_row;
   logic [FRAC_BITS-1:0] fx, fy;
   logic [FRAC_BITS:0]   gx, gy;
   logic [PW-1:0]        p_br, p_bl, p_tr;
   logic [PW+WEIGHT_SHIFT-1:0] t_br, t_bl, t_tr;
   bps_weights_type      wt;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [YW-1:0]    r,
                                                   input logic [XW-1:0]    c,
                                                   input logic [DIM_W-1:0] w);
      logic [SUM_W-1:0] s;
      s = SUM_W'(r) * SUM_W'(w) + SUM_W'(c);
      return s[ADDR_W-1:0];
   endfunction

   assign is_sample  = (kind1_ff == REQ_SAMPLE);
   assign leave      = !is_sample || !v2_ff || s2_ready;
   assign adv1       = v1_ff && leave;
   assign req_tready = !v1_ff || leave;
   assign accept     = req_tvalid && req_tready;

   assign idx_ext = 32'(idx1_ff);
   assign wr_en   = adv1 && !is_sample && (idx_ext < 32'(DEPTH));
   assign wr_addr = idx_ext[ADDR_W-1:0];
   assign wr_data = pix1_ff;
   assign rd_en   = adv1 && is_sample;

   always_comb begin
      lim_x = COORD_W'(width_eff) << FRAC_BITS;
      lim_y = COORD_W'(height_eff) << FRAC_BITS;
      oor   = xc1_ff[COORD_W-1] || yc1_ff[COORD_W-1] ||
              (xc1_ff >= lim_x) || (yc1_ff >= lim_y);

      col1 = xc1_ff[FRAC_BITS +: XW];
      row1 = yc1_ff[FRAC_BITS +: YW];
      fx   = xc1_ff[FRAC_BITS-1:0];
      fy   = yc1_ff[FRAC_BITS-1:0];

      last_col = width_eff - DIM_W'(1);
      last_row = height_eff - DIM_W'(1);
      col2_pre = {1'b0, col1} + (XW + 1)'(fx != '0);
      row2_pre = {1'b0, row1} + (YW + 1)'(fy != '0);
      if (32'(col2_pre) > 32'(last_col)) begin
         col2 = XW'(last_col);
      end else begin
         col2 = col2_pre[XW-1:0];
      end
      if (32'(row2_pre) > 32'(last_row)) begin
         row2 = YW'(last_row);
      end else begin
         row2 = row2_pre[YW-1:0];
      end

      gx   = FRAC_ONE - {1'b0, fx};
      gy   = FRAC_ONE - {1'b0, fy};
      p_br = PW'(fx) * PW'(fy);
      p_bl = PW'(gx) * PW'(fy);
      p_tr = PW'(fx) * PW'(gy);
      t_br = {p_br, {WEIGHT_SHIFT{1'b0}}};
      t_bl = {p_bl, {WEIGHT_SHIFT{1'b0}}};
      t_tr = {p_tr, {WEIGHT_SHIFT{1'b0}}};
      wt.br  = t_br[2 * FRAC_BITS +: WEIGHT_W];
      wt.bl  = t_bl[2 * FRAC_BITS +: WEIGHT_W];
      wt.tr  = t_tr[2 * FRAC_BITS +: WEIGHT_W];
      wt.tl  = WEIGHT_ONE - wt.br - wt.bl - wt.tr;
      wt.oor = oor;
   end

   assign rd_addr_tl = cell_addr(row1, col1, width_eff);
   assign rd_addr_tr = cell_addr(row1, col2, width_eff);
   assign rd_addr_bl = cell_addr(row2, col1, width_eff);
   assign rd_addr_br = cell_addr(row2, col2, width_eff);

   always_comb begin
      v1_in = v1_ff;
      if (accept) begin
         v1_in = 1'b1;
      end else if (adv1) begin
         v1_in = 1'b0;
      end
      v2_in = v2_ff;
      if (rd_en) begin
         v2_in = 1'b1;
      end else if (s2_ready) begin
         v2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (accept) begin
         kind1_ff <= req_tuser;
         idx1_ff  <= req_tdata[INDEX_W-1:0];
         pix1_ff  <= req_tdata[INDEX_W +: PIXEL_W];
         xc1_ff   <= req_tdata[INDEX_W + PIXEL_W +: COORD_W];
         yc1_ff   <= req_tdata[INDEX_W + PIXEL_W + COORD_W +: COORD_W];
      end
      if (rd_en) begin
         wt2_ff <= wt;
      end
   end

   assign s2_valid   = v2_ff;
   assign s2_weights = wt2_ff;

endmodule

FILE: design/bps_blend.sv
// ----------------------------------------------------------------------------
// bps_blend
// Weights each channel of the four neighbours, sums, scales and clamps; zeroes out-of-range samples.
// ----------------------------------------------------------------------------
module bps_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           s2_valid,
   output logic                           s2_ready,
   input  bps_pkg::bps_weights_type       s2_weights,
   input  bps_pkg::bps_corners_type       corners,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import bps_pkg::*;

   logic                v3_ff, v3_in;
   logic                oor3_ff;
   logic [PROD_W-1:0]   prod_ff [CHAN_N][CORNER_N];
   logic [PROD_W-1:0]   prod_in [CHAN_N][CORNER_N];
   logic                v4_ff, v4_in;
   logic                oor4_ff;
   logic [PIXEL_W-1:0]  pix4_ff, pix4_in;
   logic                rdy3, rdy4;
   logic                adv2, adv3;

   assign rdy4     = !v4_ff || rsp_tready;
   assign rdy3     = !v3_ff || rdy4;
   assign s2_ready = rdy3;
   assign adv2     = s2_valid && rdy3;
   assign adv3     = v3_ff && rdy4;

   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         prod_in[c][0] = PROD_W'(corners.tl[CHAN_W*c +: CHAN_W]) * PROD_W'(s2_weights.tl);
         prod_in[c][1] = PROD_W'(corners.tr[CHAN_W*c +: CHAN_W]) * PROD_W'(s2_weights.tr);
         prod_in[c][2] = PROD_W'(corners.bl[CHAN_W*c +: CHAN_W]) * PROD_W'(s2_weights.bl);
         prod_in[c][3] = PROD_W'(corners.br[CHAN_W*c +: CHAN_W]) * PROD_W'(s2_weights.br);
      end
   end

   always_comb begin
      logic [ACC_W-1:0] acc;
      logic [ACC_W-WEIGHT_SHIFT-1:0] scaled;
      pix4_in = '0;
      for (int c = 0; c < CHAN_N; c++) begin
         acc = ACC_W'(prod_ff[c][0]) + ACC_W'(prod_ff[c][1]) +
               ACC_W'(prod_ff[c][2]) + ACC_W'(prod_ff[c][3]);
         scaled = acc[ACC_W-1:WEIGHT_SHIFT];
         if (scaled > (ACC_W - WEIGHT_SHIFT)'(CHAN_MAX)) begin
            pix4_in[CHAN_W*c +: CHAN_W] = CHAN_MAX;
         end else begin
            pix4_in[CHAN_W*c +: CHAN_W] = scaled[CHAN_W-1:0];
         end
      end
      if (oor3_ff) begin
         pix4_in = '0;
      end
   end

   always_comb begin
      v3_in = v3_ff;
      if (adv2) begin
         v3_in = 1'b1;
      end else if (rdy4) begin
         v3_in = 1'b0;
      end
      v4_in = v4_ff;
      if (adv3) begin
         v4_in = 1'b1;
      end else if (rsp_tready) begin
         v4_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
      if (adv2) begin
         prod_ff <= prod_in;
         oor3_ff <= s2_weights.oor;
      end
      if (adv3) begin
         pix4_ff <= pix4_in;
         oor4_ff <= oor3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = pix4_ff;
   assign rsp_tuser  = oor4_ff;

endmodule

FILE: design/bilinear_pixel_sampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_pixel_sampler_unit
// Bilinear sampler over an RGBA8 frame store held in two banks.
// ----------------------------------------------------------------------------
// path: a sample word is registered at input, at the bank reads and weights, at the products and at the result
// throughput: one word per cycle while the result port does not stall, writes and samples mixed; each bank reads
//   two neighbours per cycle, so all four corners come in one read
// reset: clears the pipeline valids and sets width and height to 64;
//   the frame store is not cleared
module bilinear_pixel_sampler_unit #(
   parameter int MAX_WIDTH  = bps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bps_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = bps_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // pixel_index, pixel_value, x_fixed, y_fixed
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bps_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type
   input  logic                            req_tuser,
   // sampled_pixel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // out_of_range
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bps_pkg::DIM_W-1:0]       csr_wdata
);
   import bps_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [DIM_W-1:0]   frame_width_ff, frame_width_in;
   logic [DIM_W-1:0]   frame_height_ff, frame_height_in;
   logic [DIM_W-1:0]   width_eff, height_eff;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [PIXEL_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr_tl, rd_addr_tr, rd_addr_bl, rd_addr_br;
   logic               s2_valid, s2_ready;
   bps_weights_type    s2_weights;
   bps_corners_type    corners;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_RESET;
         frame_height_ff <= DIM_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   always_comb begin
      width_eff  = frame_width_ff;
      height_eff = frame_height_ff;
      if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end
      if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end
   end

   bps_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr_tl (rd_addr_tl),
      .rd_addr_tr (rd_addr_tr),
      .rd_addr_bl (rd_addr_bl),
      .rd_addr_br (rd_addr_br),
      .s2_valid   (s2_valid),
      .s2_ready   (s2_ready),
      .s2_weights (s2_weights)
   );

   // top row bank
   bps_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_bank_top (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_tl),
      .rd_addr_b (rd_addr_tr),
      .rd_data_a (corners.tl),
      .rd_data_b (corners.tr)
   );

   // bottom row bank
   bps_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_bank_bot (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_bl),
      .rd_addr_b (rd_addr_br),
      .rd_data_a (corners.bl),
      .rd_data_b (corners.br)
   );

   bps_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2_ready   (s2_ready),
      .s2_weights (s2_weights),
      .corners    (corners),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: design/bps_checker.sv
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks of the bilinear pixel sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bps_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   // pending result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // out of frame gives a black pixel
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out of range result with nonzero pixel");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // config port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write not taken");

endmodule

bind bilinear_pixel_sampler_unit bps_checker u_bps_checker (.*);
